@@ src/kws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kws_pkg
// Shared types and constants of the keyed word store.
// ----------------------------------------------------------------------------
package kws_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = 11;
	localparam int KEY_W         = 416;
	localparam int HASH_W        = 448;
	localparam int VAL_W         = 256;
	localparam int BYTE_CNT      = 56;
	localparam int BYTE_W        = $clog2(BYTE_CNT + 1);
	localparam int CNT_PROD_W    = CNT_W + 4;
	localparam logic [CNT_PROD_W-1:0] FILL_LIMIT = CNT_PROD_W'(TABLE_ENTRIES * 7);

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HASH,
		ST_RD,
		ST_WAIT,
		ST_CMP,
		ST_VRD,
		ST_VWAIT,
		ST_COMMIT,
		ST_CLEAR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} hash_ctl_t;

endpackage

@@ src/keyed_word_store_hash_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_word_store_hash_table
// Key-value store with FNV-1a hashing and linear probing.
// ----------------------------------------------------------------------------
// One request enters on s_axis (action, address, slot, value) and one result
// leaves on m_axis (read or prior value, status). The key is hashed one byte
// per cycle over 56 bytes, then each probe reads the key memory and compares
// the key, and the value is read and written after the last probe; m_axis_tvalid
// rises once the commit ends, and no new request is taken until the result left.
// A clear sweeps the used marks, one per cycle, over all TABLE_ENTRIES
// entries; an unused action code answers on the next cycle. s_axis_tready is
// high only while idle. The result is held in the output register until
// taken; a stalled receiver holds the block. Reset empties the entry count
// and then sweeps all TABLE_ENTRIES used marks with s_axis_tready low.
// ----------------------------------------------------------------------------
module keyed_word_store_hash_table import kws_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action, addr_word_high, addr_word_mid, addr_word_low, slot_word_3..0,
	// value_word_3..0, zero filled
	input  logic [679:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// read_value_word_3..0, status, zero filled
	output logic [263:0] m_axis_tdata
);

	state_t state_q, state_d;

	logic [1:0]       act_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] res_q;
	logic             stat_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W:0]   probes_q;
	logic [CNT_W-1:0] cnt_q;
	logic             found_q;
	logic             init_q;
	logic             used_rd_q;

	logic             used_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
	logic [VAL_W-1:0] val_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0] key_rd_q;
	logic [VAL_W-1:0] val_rd_q;

	logic [HASH_W-1:0] key_in;
	logic [63:0]       hash;
	hash_ctl_t         hctl;
	logic              hstart;
	logic [CNT_PROD_W-1:0] cnt_x10;

	// key bytes in hashing order: addr high, mid, low, slot 3..0, LSB first
	assign key_in = {s_axis_tdata[417:34], 32'd0, s_axis_tdata[33:2]};

	kws_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hstart),
		.key    (key_in),
		.ctl    (hctl),
		.hash   (hash)
	);

	assign cnt_x10 = (CNT_PROD_W'(cnt_q) << 3) + (CNT_PROD_W'(cnt_q) << 1);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign hstart        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {7'd0, stat_q, res_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (hstart) begin
					case (action_t'(s_axis_tdata[1:0]))
						ACT_READ, ACT_WRITE: state_d = ST_HASH;
						ACT_CLEAR:           state_d = ST_CLEAR;
						default:             state_d = ST_OUT;
					endcase
				end
			end
			ST_HASH:   if (!hctl.busy && !hctl.start) state_d = ST_RD;
			ST_RD:     state_d = ST_WAIT;
			ST_WAIT:   state_d = ST_CMP;
			ST_CMP: begin
				if (!used_rd_q || key_rd_q == key_q)
					state_d = ST_VRD;
				else if (probes_q == (IDX_W+1)'(TABLE_ENTRIES - 1))
					state_d = ST_VRD;
				else
					state_d = ST_RD;
			end
			ST_VRD:    state_d = ST_VWAIT;
			ST_VWAIT:  state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_OUT;
			ST_CLEAR: begin
				if (idx_q == IDX_W'(TABLE_ENTRIES - 1))
					state_d = init_q ? ST_IDLE : ST_OUT;
			end
			ST_OUT:    if (m_axis_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			init_q   <= 1'b1;
			idx_q    <= '0;
			cnt_q    <= '0;
			probes_q <= '0;
			found_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					probes_q <= '0;
					found_q  <= 1'b0;
					idx_q    <= '0;
				end
				ST_HASH: idx_q <= hash[IDX_W-1:0];
				ST_CMP: begin
					if (used_rd_q && key_rd_q == key_q)
						found_q <= 1'b1;
					else if (used_rd_q)
						probes_q <= probes_q + 1'b1;
					if (used_rd_q && key_rd_q != key_q &&
							probes_q != (IDX_W+1)'(TABLE_ENTRIES - 1))
						idx_q <= idx_q + 1'b1;
				end
				ST_COMMIT: begin
					if (act_q == ACT_WRITE && !found_q && !used_rd_q &&
							cnt_x10 < FILL_LIMIT)
						cnt_q <= cnt_q + 1'b1;
				end
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					cnt_q <= '0;
					if (idx_q == IDX_W'(TABLE_ENTRIES - 1))
						init_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q  <= s_axis_tdata[1:0];
				key_q  <= s_axis_tdata[417:2];
				val_q  <= {s_axis_tdata[673:610], s_axis_tdata[609:546],
					s_axis_tdata[545:482], s_axis_tdata[481:418]};
				res_q  <= '0;
				stat_q <= 1'b0;
			end
			ST_RD: begin
				key_rd_q  <= key_mem[idx_q];
				used_rd_q <= used_mem[idx_q];
			end
			ST_VRD: val_rd_q <= val_mem[idx_q];
			ST_COMMIT: begin
				if (found_q)
					res_q <= val_rd_q;
				if (act_q == ACT_WRITE) begin
					if (found_q)
						val_mem[idx_q] <= val_q;
					else if (!used_rd_q && cnt_x10 < FILL_LIMIT) begin
						val_mem[idx_q]  <= val_q;
						key_mem[idx_q]  <= key_q;
						used_mem[idx_q] <= 1'b1;
					end else
						stat_q <= 1'b1;
				end
			end
			ST_CLEAR: used_mem[idx_q] <= 1'b0;
			default: ;
		endcase
	end

endmodule

@@ src/kws_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kws_hash
// Byte-serial FNV-1a 64 over a 56-byte key, one byte per cycle.
// ----------------------------------------------------------------------------
module kws_hash import kws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] key,
	output hash_ctl_t         ctl,
	output logic [63:0]       hash
);

	logic [HASH_W-1:0] key_q;
	logic [BYTE_W-1:0] cnt_q;
	logic [63:0]       h_q;
	logic              busy_q;
	logic [63:0]       x;
	logic [63:0]       prod;

	assign x    = h_q ^ {56'd0, key_q[7:0]};
	// prime = 2^40 + 0x1b3
	assign prod = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == BYTE_W'(BYTE_CNT - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			h_q   <= FNV_BASIS;
		end else if (busy_q) begin
			key_q <= key_q >> 8;
			h_q   <= prod;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign hash      = h_q;

endmodule
